FILE: sv/egb_pkg.sv
// egb_pkg: shared types, constants and state encoding for the epsilon-greedy
// bandit agent. No dependencies; used by epsilon_greedy_bandit_agent_top.
package egb_pkg;

    localparam int VALUE_W           = 17;
    localparam int CFG_W             = 17;
    localparam int CFG_IDX_W         = 2;
    localparam int ARM_COUNT_DEFAULT = 8;

    localparam logic [VALUE_W-1:0] Q_ONE         = 17'd65536;
    localparam logic [CFG_W-1:0]   EPSILON_RESET = 17'd26214;
    localparam logic [CFG_W-1:0]   ALPHA_RESET   = 17'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd1;

    localparam logic CMD_CHOOSE = 1'b0;
    localparam logic CMD_LEARN  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] explore_draw;
        logic [2:0]  random_arm;
        logic [2:0]  arm;
        logic        reward;
    } in_t;

    typedef struct packed {
        logic [2:0]         chosen_arm;
        logic               explored;
        logic [VALUE_W-1:0] new_value;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

FILE: sv/egb_ram.sv
// egb_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module egb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/epsilon_greedy_bandit_agent_top.sv
// epsilon_greedy_bandit_agent_top: value table in egb_ram, explore/exploit choice,
// learning update and output register. Depends on egb_pkg and egb_ram.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    egb_pkg::in_t  (command, draw, arms, reward)
//   m_        out        m_valid/m_ready    egb_pkg::out_t (chosen_arm, explored, value)
//   cfg_      in         cfg_wr_en          cfg_index, cfg_data (epsilon, alpha)
//
// greedy choose scans the table one entry per cycle through the single RAM read
// port. explore reads the picked entry and outputs it; learn goes through read,
// multiply, write back and output. one transaction is in work at a time;
// a new one is taken while the previous result still sits in the output register.
// reset (synchronous) clears per-entry valid bits, so the table reads as zero at once.
module epsilon_greedy_bandit_agent_top #(
    parameter int ARM_COUNT = egb_pkg::ARM_COUNT_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  egb_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output egb_pkg::out_t                m_data,
    input  logic                         cfg_wr_en,
    input  logic [egb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [egb_pkg::CFG_W-1:0]    cfg_data
);

    localparam int ARM_W = (ARM_COUNT > 1) ? $clog2(ARM_COUNT) : 1;
    localparam logic [6:0] ARM_COUNT_W = 7'(ARM_COUNT);
    localparam int VW = egb_pkg::VALUE_W;

    function automatic logic [ARM_W-1:0] arm_wrap(input logic [2:0] raw);
        logic [6:0] r;
        r = {4'd0, raw};
        for (int k = 0; k < 3; k++) begin
            if (r >= ARM_COUNT_W) begin
                r = r - ARM_COUNT_W;
            end
        end
        return r[ARM_W-1:0];
    endfunction

    egb_pkg::state_t state_reg, state_next;

    logic [egb_pkg::CFG_W-1:0] epsilon_reg;
    logic [egb_pkg::CFG_W-1:0] alpha_reg;
    logic [ARM_COUNT-1:0]      valid_reg;

    logic                  cmd_reg;
    logic                  reward_reg;
    logic                  expl_reg;
    logic [ARM_W-1:0]      pick_reg;
    logic [VW-1:0]         val_reg;
    logic [ARM_W-1:0]      cmp_idx_reg;
    logic                  rd_valid_reg;
    logic signed [35:0]    prod_reg;
    logic                  m_valid_reg;
    egb_pkg::out_t         m_data_reg;

    logic                  accept;
    logic                  explore_hit;
    logic                  scan_last;
    logic                  out_free;
    logic                  rd_en;
    logic [ARM_W-1:0]      rd_addr;
    logic                  ram_we;
    logic [VW-1:0]         ram_rd_data;
    logic [VW-1:0]         eff_val;
    logic [VW-1:0]         alpha_clamp;
    logic signed [17:0]    diff;
    logic signed [36:0]    prod_shift;
    logic signed [36:0]    nv_wide;
    logic [VW-1:0]         nv;
    logic [6:0]            pick_ext;

    egb_ram #(
        .WIDTH (VW),
        .DEPTH (ARM_COUNT)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (pick_reg),
        .wr_data (nv),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign accept      = s_valid && s_ready;
    assign explore_hit = {1'b0, s_data.explore_draw} < epsilon_reg;
    assign scan_last   = 7'(cmp_idx_reg) == (ARM_COUNT_W - 7'd1);
    assign out_free    = !m_valid_reg || m_ready;
    // entries never written since reset read as zero
    assign eff_val     = rd_valid_reg ? ram_rd_data : '0;

    // learning datapath
    assign alpha_clamp = (alpha_reg > egb_pkg::Q_ONE) ? egb_pkg::Q_ONE : alpha_reg;
    assign diff        = (reward_reg ? 18'sd65536 : 18'sd0) - $signed({1'b0, eff_val});
    assign prod_shift  = 37'(prod_reg >>> 16);
    assign nv_wide     = $signed({20'd0, val_reg}) + prod_shift;

    always_comb begin
        if (nv_wide < 0) begin
            nv = '0;
        end else if (nv_wide > $signed({20'd0, egb_pkg::Q_ONE})) begin
            nv = egb_pkg::Q_ONE;
        end else begin
            nv = nv_wide[VW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            egb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.command == egb_pkg::CMD_CHOOSE && !explore_hit) begin
                        state_next = egb_pkg::ST_SCAN;
                    end else begin
                        state_next = egb_pkg::ST_READ;
                    end
                end
            end
            egb_pkg::ST_READ: begin
                state_next = (cmd_reg == egb_pkg::CMD_LEARN) ? egb_pkg::ST_MUL
                                                            : egb_pkg::ST_DONE;
            end
            egb_pkg::ST_MUL: begin
                state_next = egb_pkg::ST_DONE;
            end
            egb_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = egb_pkg::ST_DONE;
                end
            end
            egb_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = egb_pkg::ST_IDLE;
                end
            end
            default: state_next = egb_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        ram_we  = 1'b0;
        unique case (state_reg)
            egb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid;
                if (s_data.command == egb_pkg::CMD_LEARN) begin
                    rd_addr = arm_wrap(s_data.arm);
                end else if (explore_hit) begin
                    rd_addr = arm_wrap(s_data.random_arm);
                end
            end
            egb_pkg::ST_SCAN: begin
                rd_en   = !scan_last;
                rd_addr = scan_last ? '0 : cmp_idx_reg + 1'b1;
            end
            egb_pkg::ST_MUL: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= egb_pkg::ST_IDLE;
            epsilon_reg <= egb_pkg::EPSILON_RESET;
            alpha_reg   <= egb_pkg::ALPHA_RESET;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    egb_pkg::CFG_EPSILON: epsilon_reg <= cfg_data;
                    egb_pkg::CFG_ALPHA:   alpha_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ram_we) begin
                valid_reg[pick_reg] <= 1'b1;
            end
            if (state_reg == egb_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        case (state_reg)
            egb_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_reg     <= s_data.command;
                    reward_reg  <= s_data.reward;
                    cmp_idx_reg <= '0;
                    val_reg     <= '0;
                    if (s_data.command == egb_pkg::CMD_LEARN) begin
                        pick_reg <= arm_wrap(s_data.arm);
                        expl_reg <= 1'b0;
                    end else if (explore_hit) begin
                        pick_reg <= arm_wrap(s_data.random_arm);
                        expl_reg <= 1'b1;
                    end else begin
                        pick_reg <= '0;
                        expl_reg <= 1'b0;
                    end
                end
            end
            egb_pkg::ST_READ: begin
                val_reg  <= eff_val;
                prod_reg <= $signed({1'b0, alpha_clamp}) * diff;
            end
            egb_pkg::ST_MUL: begin
                val_reg <= nv;
            end
            egb_pkg::ST_SCAN: begin
                // strict compare keeps the lowest index on ties
                if (eff_val > val_reg) begin
                    val_reg  <= eff_val;
                    pick_reg <= cmp_idx_reg;
                end
                cmp_idx_reg <= cmp_idx_reg + 1'b1;
            end
            egb_pkg::ST_DONE: begin
                if (out_free) begin
                    m_data_reg.chosen_arm <= pick_ext[2:0];
                    m_data_reg.explored   <= expl_reg;
                    m_data_reg.new_value  <= val_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign pick_ext = 7'(pick_reg);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    a_learn_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == egb_pkg::ST_MUL) |=> valid_reg[$past(pick_reg)])
        else $error("learned entry not marked valid");

    a_pick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != egb_pkg::ST_IDLE) |-> (7'(pick_reg) < ARM_COUNT_W))
        else $error("arm index outside table");

    a_value_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.new_value <= egb_pkg::Q_ONE))
        else $error("result value above one");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == egb_pkg::ST_DONE))
        else $error("result loaded outside done state");

endmodule
